// ----- hdl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Configuration register indexes.
    localparam int               CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TPS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO  = 3'd5;

    localparam int REG_W   = 32;
    localparam int TPS_W   = 30;
    localparam int TRIG_W  = 16;
    localparam int DIST_W  = 10;

    // Distance conversion: inches = width * 6750 / ticks_per_second.
    localparam int                  SCALE_BITS = 13;
    localparam logic [SCALE_BITS-1:0] INCH_SCALE = 13'd6750;
    localparam logic [DIST_W-1:0]   DIST_SAT   = 10'd1000;

    // Quotient bits kept by the divider; a larger quotient saturates.
    localparam int DIV_STEPS = 11;
    localparam int QUO_W     = DIV_STEPS;

    // Step counter of the arithmetic sequencer.
    localparam int                STEP_W    = 4;
    localparam logic [STEP_W-1:0] MUL_LAST  = 4'(SCALE_BITS - 1);
    localparam logic [STEP_W-1:0] DIV_FIRST = 4'(DIV_STEPS);

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        K_TICK,
        K_OOR,
        K_MEAS,
        K_REPORT
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  trig;
    } t_tag;

    typedef struct packed {
        logic              enable;
        logic [TPS_W-1:0]  tps;
        logic [TRIG_W-1:0] trig_ticks;
        logic [REG_W-1:0]  period;
        logic [REG_W-1:0]  min_echo;
        logic [REG_W-1:0]  max_echo;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ----- hdl/uer_front.sv -----
// Front end: tick timing, trigger generation and echo width classification.
module uer_front import uer_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_mode,
    input  logic                   i_echo,
    input  logic                   i_full,
    output logic                   o_push,
    output t_tag                   o_tag,
    output logic [COUNT_WIDTH-1:0] o_width
);

    localparam int CW = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;

    logic                   r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_ewc, n_ewc;
    logic [COUNT_WIDTH-1:0] r_pc, n_pc;
    logic [COUNT_WIDTH:0]   pc_inc;
    logic                   trig_now;
    logic                   out_of_bounds;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_width = r_ewc;

    assign trig_now      = CW'(r_pc) < CW'(i_cfg.trig_ticks);
    assign pc_inc        = {1'b0, r_pc} + 1'b1;
    assign out_of_bounds = (CW'(r_ewc) < CW'(i_cfg.min_echo)) ||
                           (CW'(r_ewc) > CW'(i_cfg.max_echo));

    always_comb begin
        n_prev     = r_prev;
        n_ewc      = r_ewc;
        n_pc       = r_pc;
        o_tag.kind = K_TICK;
        o_tag.trig = 1'b0;
        if (i_mode) begin
            o_tag.kind = K_REPORT;
            o_tag.trig = i_cfg.enable && trig_now;
        end else if (!i_cfg.enable) begin
            n_prev = 1'b0;
            n_ewc  = '0;
            n_pc   = '0;
        end else begin
            o_tag.trig = trig_now;
            if (pc_inc[COUNT_WIDTH] || (CW'(pc_inc) >= CW'(i_cfg.period))) begin
                n_pc = '0;
            end else begin
                n_pc = pc_inc[COUNT_WIDTH-1:0];
            end
            if (i_echo) begin
                if (!r_prev) begin
                    n_ewc = COUNT_WIDTH'(1);
                end else if (r_ewc != '1) begin
                    n_ewc = r_ewc + 1'b1;
                end
            end else if (r_prev) begin
                o_tag.kind = out_of_bounds ? K_OOR : K_MEAS;
                n_ewc      = '0;
            end
            n_prev = i_echo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_ewc  <= '0;
            r_pc   <= '0;
        end else if (o_push) begin
            r_prev <= n_prev;
            r_ewc  <= n_ewc;
            r_pc   <= n_pc;
        end
    end

endmodule

// ----- hdl/uer_queue.sv -----
// Small first-in first-out queue between the front and back ends.
module uer_queue import uer_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/uer_back.sv -----
// Back end: distance conversion, running minimum and maximum, result register.
module uer_back import uer_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  t_tag                   i_q_tag,
    input  logic [COUNT_WIDTH-1:0] i_q_width,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_trigger_level,
    output logic                   o_measurement_done,
    output logic                   o_out_of_range,
    output logic [DIST_W-1:0]      o_distance_inches,
    output logic [DIST_W-1:0]      o_min_inches,
    output logic [DIST_W-1:0]      o_max_inches
);

    localparam int PROD_W = COUNT_WIDTH + SCALE_BITS;
    localparam int DVS_W  = TPS_W + DIV_STEPS;
    localparam int DW     = (PROD_W > DVS_W) ? PROD_W : DVS_W;

    t_back_state r_state, n_state;

    logic                   r_out_valid;
    logic [DIST_W-1:0]      r_min, r_max;
    logic                   r_trig;
    logic [COUNT_WIDTH-1:0] r_w;
    logic [DW-1:0]          r_acc;
    logic [DW-1:0]          r_dvs;
    logic [STEP_W-1:0]      r_step;
    logic [QUO_W-1:0]       r_quo;
    logic                   r_sat;

    logic                   slot_free;
    logic                   pop;
    logic                   load_meas;
    logic                   load_direct;
    logic                   ge;
    logic                   sat_now;
    logic [DIST_W-1:0]      meas_inches;
    logic [DIST_W-1:0]      new_min, new_max;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign ge          = (r_acc >= r_dvs);
    assign sat_now     = (r_step == DIV_FIRST) && ge;
    assign meas_inches = (r_sat || (r_quo > QUO_W'(DIST_SAT))) ? DIST_SAT
                                                                : r_quo[DIST_W-1:0];
    assign new_min     = (meas_inches < r_min) ? meas_inches : r_min;
    assign new_max     = (meas_inches > r_max) ? meas_inches : r_max;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && (i_q_tag.kind == K_MEAS)) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                if (r_step == '0) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (sat_now || (r_step == '0)) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        pop         = 1'b0;
        load_direct = 1'b0;
        load_meas   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && (i_q_tag.kind == K_MEAS)) begin
                    pop = 1'b1;
                end else if (i_q_valid && slot_free) begin
                    pop         = 1'b1;
                    load_direct = 1'b1;
                end
            end
            BK_OUT: begin
                load_meas = slot_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_min       <= DIST_SAT;
            r_max       <= '0;
        end else begin
            r_state <= n_state;
            if (load_direct || load_meas) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_direct && (i_q_tag.kind == K_REPORT)) begin
                r_min <= DIST_SAT;
                r_max <= '0;
            end else if (load_meas) begin
                r_min <= new_min;
                r_max <= new_max;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_direct) begin
            o_trigger_level    <= i_q_tag.trig;
            o_measurement_done <= (i_q_tag.kind == K_OOR);
            o_out_of_range     <= (i_q_tag.kind == K_OOR);
            o_distance_inches  <= '0;
            o_min_inches       <= r_min;
            o_max_inches       <= r_max;
        end else if (load_meas) begin
            o_trigger_level    <= r_trig;
            o_measurement_done <= 1'b1;
            o_out_of_range     <= 1'b0;
            o_distance_inches  <= meas_inches;
            o_min_inches       <= new_min;
            o_max_inches       <= new_max;
        end
    end

    // Shift-and-add multiply by the scale, then restoring division by the tick rate.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (pop && (i_q_tag.kind == K_MEAS)) begin
                    r_w    <= i_q_width;
                    r_trig <= i_q_tag.trig;
                    r_acc  <= '0;
                    r_step <= MUL_LAST;
                    r_sat  <= 1'b0;
                    r_quo  <= '0;
                end
            end
            BK_MUL: begin
                r_acc <= (r_acc << 1) + (INCH_SCALE[r_step] ? DW'(r_w) : '0);
                if (r_step == '0) begin
                    r_dvs  <= DW'({i_cfg.tps, {DIV_STEPS{1'b0}}});
                    r_step <= DIV_FIRST;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            BK_DIV: begin
                if (r_step == DIV_FIRST) begin
                    r_sat <= ge;
                end else if (ge) begin
                    r_acc <= r_acc - r_dvs;
                end
                r_quo  <= {r_quo[QUO_W-2:0], ge && (r_step != DIV_FIRST)};
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

endmodule

// ----- hdl/ultrasonic_echo_ranger_top.sv -----
// Top level of the ultrasonic echo ranger: configuration registers and block wiring.
//
// Each input transfer is one sensor tick (mode 0, with the sampled echo pin) or a
// report request (mode 1), and each one yields exactly one result transfer, in order.
// While enabled, the trigger output is high for trigger_ticks ticks at the start of
// every period_ticks ticks. The echo pulse width is counted; on its falling edge the
// width is checked against [min_echo_ticks, max_echo_ticks] and, when inside, turned
// into floor(width * 6750 / ticks_per_second) inches, saturated at 1000, which also
// updates the running minimum and maximum. A report returns the minimum and maximum
// and clears them to 1000 and 0. The front end takes one transfer per clock while the
// queue is not full and keeps all tick timing; a four-entry queue hands each classified
// item to the back end. Ticks, reports and out-of-range echoes go straight from the
// queue into the result register. A measurement inside the bounds occupies the back
// end: it is taken from the queue, multiplied by 6750 with shift-and-add over the 13
// scale bits, divided by the tick rate with restoring division (a saturation check,
// then one quotient bit per cycle) and loaded once the result slot is free. Ticks
// behind it fill the queue up to four items; then input ready drops until it pops again.
// Configuration writes take effect at once and must only be made while no result is
// outstanding; the configuration port is always ready. A write to an unused index is
// accepted and ignored.
module ultrasonic_echo_ranger_top import uer_pkg::*; #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // Input item channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic                 i_echo_level,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_trigger_level,
    output logic                 o_measurement_done,
    output logic                 o_out_of_range,
    output logic [DIST_W-1:0]    o_distance_inches,
    output logic [DIST_W-1:0]    o_min_inches,
    output logic [DIST_W-1:0]    o_max_inches
);

    localparam int Q_W = $bits(t_tag) + COUNT_WIDTH;

    t_cfg                   r_cfg;
    logic                   q_push;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    t_tag                   f_tag;
    logic [COUNT_WIDTH-1:0] f_width;
    logic [Q_W-1:0]         q_data;
    t_tag                   q_tag;
    logic [COUNT_WIDTH-1:0] q_width;

    // The register file never stalls a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b0;
            r_cfg.tps        <= 30'd1000000;
            r_cfg.trig_ticks <= 16'd10;
            r_cfg.period     <= 32'd100000;
            r_cfg.min_echo   <= 32'd100;
            r_cfg.max_echo   <= 32'd18001;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ENABLE:   r_cfg.enable     <= i_cfg_data[0];
                REG_TPS:      r_cfg.tps        <= i_cfg_data[TPS_W-1:0];
                REG_TRIG:     r_cfg.trig_ticks <= i_cfg_data[TRIG_W-1:0];
                REG_PERIOD:   r_cfg.period     <= i_cfg_data;
                REG_MIN_ECHO: r_cfg.min_echo   <= i_cfg_data;
                REG_MAX_ECHO: r_cfg.max_echo   <= i_cfg_data;
                default:      r_cfg            <= r_cfg;
            endcase
        end
    end

    uer_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mode  (i_mode),
        .i_echo  (i_echo_level),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_tag   (f_tag),
        .o_width (f_width)
    );

    uer_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_tag, f_width}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // Unpack the queue head into its tag and echo width.
    assign q_tag   = t_tag'(q_data[Q_W-1:COUNT_WIDTH]);
    assign q_width = q_data[COUNT_WIDTH-1:0];

    uer_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_q_tag            (q_tag),
        .i_q_width          (q_width),
        .o_q_pop            (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_trigger_level    (o_trigger_level),
        .o_measurement_done (o_measurement_done),
        .o_out_of_range     (o_out_of_range),
        .o_distance_inches  (o_distance_inches),
        .o_min_inches       (o_min_inches),
        .o_max_inches       (o_max_inches)
    );

    // An out-of-range result always ends a measurement and carries no distance.
    a_oor_implies_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_measurement_done && (o_distance_inches == '0))
        else $error("out-of-range result without measurement_done or with a distance");

    // A valid measurement lies within the running minimum and maximum it updated.
    a_dist_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_measurement_done && !o_out_of_range |->
            (o_min_inches <= o_distance_inches) &&
            (o_distance_inches <= o_max_inches) &&
            (o_distance_inches <= DIST_SAT))
        else $error("measured distance outside running min/max or above saturation");

    // The queue is never popped while empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

endmodule
